### sv/vmpm_pkg.sv
package vmpm_pkg;
  localparam logic [29:0] MODULUS = 30'd998244353;
  localparam int unsigned DIM_CAP = 16;
  // floor(2^60 / p), the Barrett reciprocal for products below 2^60
  localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'(MODULUS));

  typedef enum logic [1:0] {
    OP_LOAD_MATRIX = 2'd0,
    OP_LOAD_VECTOR = 2'd1,
    OP_START       = 2'd2,
    OP_NONE        = 2'd3
  } opcode_t;

  // One multiply-accumulate request to the shared MAC unit
  typedef struct packed {
    logic        clear;
    logic        valid;
    logic [29:0] a;
    logic [29:0] b;
  } mac_req_t;
endpackage

### sv/vector_matrix_power_mod_prime_unit.sv
// s_tready stays low until a request is finished; a load is written in S_LOAD.
// A start at size n runs, per exponent bit up to the top set bit, a squaring of the
// matrix, preceded by a vector-times-matrix pass when the bit is set: each entry is n
// MACs through the one shared unit, a store and a copy-back from the scratch store.
// Results follow with m_tready high, m_tlast on the last; the whole start is one request.
// rst is synchronous, active high; size resets to 16, stores are not cleared.
module vector_matrix_power_mod_prime_unit #(
  parameter int MAX_DIM = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode[1:0], row_index[5:2], col_index[9:6], entry_value[39:10],
  // exponent[102:40], zero pad [103]
  input  logic [103:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // result_index[3:0], result_value[33:4], zero pad [39:34]
  output logic [39:0]  m_tdata,
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [4:0]   cfg_data
);
  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH = 1 << (2 * AW);
  localparam int BOUND = (MAX_DIM < vmpm_pkg::DIM_CAP) ? MAX_DIM : vmpm_pkg::DIM_CAP;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_BIT, S_RDA, S_RDB, S_MAC, S_WAIT, S_STORE,
    S_COPY, S_COPYW, S_NEXT, S_EMIT_RD, S_EMIT
  } state_t;

  state_t       state;
  logic [29:0]  matrix_mem  [DEPTH];
  logic [29:0]  scratch_mem [DEPTH];
  logic [29:0]  vector_mem  [MAX_DIM];
  logic [4:0]   active_size;
  logic [4:0]   n;
  logic [62:0]  remaining_exponent;
  logic         vec_pass;
  logic [AW-1:0] ci, cj, ck;
  logic [29:0]  opa, opb, rd_scr;
  logic [103:0] req;
  vmpm_pkg::mac_req_t mreq;
  logic         mac_busy;
  logic [29:0]  mac_acc;
  logic [4:0]   size_sat;
  logic [30:0]  val_red;
  logic [AW:0]  nlim;

  vmpm_mac u_mac (.clk(clk), .rst(rst), .req(mreq), .busy(mac_busy), .acc(mac_acc));

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign val_red   = {1'b0, req[39:10]} - {1'b0, vmpm_pkg::MODULUS};
  assign nlim      = (AW+1)'(n - 5'd1);

  always_comb begin
    size_sat = active_size;
    if (size_sat == 5'd0) size_sat = 5'd1;
    if (size_sat > 5'(BOUND)) size_sat = 5'(BOUND);
  end

  function automatic logic [AW*2-1:0] addr(input logic [AW-1:0] r, input logic [AW-1:0] c);
    addr = {r, c};
  endfunction

  always_comb begin
    mreq.clear = (state == S_RDA) && (ck == '0);
    mreq.valid = (state == S_MAC);
    mreq.a     = opa;
    mreq.b     = opb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      active_size        <= 5'd16;
      remaining_exponent <= '0;
      m_tvalid           <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) active_size <= cfg_data;
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          req   <= s_tdata;
          state <= S_LOAD;
        end
        S_LOAD: begin
          unique case (vmpm_pkg::opcode_t'(req[1:0]))
            vmpm_pkg::OP_LOAD_MATRIX: begin
              if (32'(req[5:2]) < MAX_DIM && 32'(req[9:6]) < MAX_DIM)
                matrix_mem[addr(AW'(req[5:2]), AW'(req[9:6]))] <=
                  val_red[30] ? req[39:10] : val_red[29:0];
              state <= S_IDLE;
            end
            vmpm_pkg::OP_LOAD_VECTOR: begin
              if (32'(req[9:6]) < MAX_DIM)
                vector_mem[AW'(req[9:6])] <= val_red[30] ? req[39:10] : val_red[29:0];
              state <= S_IDLE;
            end
            vmpm_pkg::OP_START: begin
              n                  <= size_sat;
              remaining_exponent <= req[102:40];
              state              <= S_BIT;
            end
            vmpm_pkg::OP_NONE: state <= S_IDLE;
            default: state <= S_IDLE;
          endcase
        end
        S_BIT: begin
          ci <= '0; cj <= '0; ck <= '0;
          if (remaining_exponent == '0) state <= S_EMIT_RD;
          else begin
            vec_pass <= remaining_exponent[0];
            state    <= S_RDA;
          end
        end
        S_RDA: begin
          opa   <= vec_pass ? vector_mem[ck] : matrix_mem[addr(ci, ck)];
          opb   <= matrix_mem[addr(ck, cj)];
          state <= S_MAC;
        end
        S_MAC: state <= S_WAIT;
        S_WAIT: if (!mac_busy) begin
          if ({1'b0, ck} == nlim) state <= S_STORE;
          else begin
            ck    <= ck + 1'b1;
            state <= S_RDA;
          end
        end
        S_STORE: begin
          scratch_mem[addr(ci, cj)] <= mac_acc;
          ck <= '0;
          if ({1'b0, cj} != nlim) begin
            cj <= cj + 1'b1; state <= S_RDA;
          end else if (!vec_pass && {1'b0, ci} != nlim) begin
            cj <= '0; ci <= ci + 1'b1; state <= S_RDA;
          end else begin
            ci <= '0; cj <= '0; state <= S_COPY;
          end
        end
        S_COPY: begin
          rd_scr <= scratch_mem[addr(ci, cj)];
          state  <= S_COPYW;
        end
        S_COPYW: begin
          if (vec_pass) vector_mem[cj] <= rd_scr;
          else matrix_mem[addr(ci, cj)] <= rd_scr;
          if ({1'b0, cj} != nlim) begin
            cj <= cj + 1'b1; state <= S_COPY;
          end else if (!vec_pass && {1'b0, ci} != nlim) begin
            cj <= '0; ci <= ci + 1'b1; state <= S_COPY;
          end else state <= S_NEXT;
        end
        S_NEXT: begin
          ci <= '0; cj <= '0; ck <= '0;
          if (vec_pass) begin
            vec_pass <= 1'b0;
            state    <= S_RDA;
          end else begin
            remaining_exponent <= remaining_exponent >> 1;
            state              <= S_BIT;
          end
        end
        S_EMIT_RD: begin
          m_tdata  <= {6'd0, vector_mem[cj], 4'(cj)};
          m_tlast  <= ({1'b0, cj} == nlim);
          m_tvalid <= 1'b1;
          state    <= S_EMIT;
        end
        S_EMIT: if (m_tready) begin
          m_tvalid <= 1'b0;
          if (m_tlast) state <= S_IDLE;
          else begin
            cj    <= cj + 1'b1;
            state <= S_EMIT_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### sv/vmpm_mac.sv
// Shared modular multiply-accumulate: acc = (acc + a*b) mod p.
// One 32x32 multiplier serves every step: the product, both halves of the
// Barrett quotient estimate and quotient times p. Busy from S_QHI through S_ADD.
module vmpm_mac (
  input  logic             clk,
  input  logic             rst,
  input  vmpm_pkg::mac_req_t req,
  output logic             busy,
  output logic [29:0]      acc
);
  typedef enum logic [2:0] {
    S_IDLE, S_QHI, S_QLO, S_QUOT, S_QMUL, S_RED, S_ADD
  } mac_state_t;

  mac_state_t  state;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] mul_p;
  logic [59:0] prod;
  logic [63:0] q_hi;
  logic [63:0] q_lo;
  logic [29:0] quot;
  logic [31:0] qp_lo;
  logic [31:0] diff;
  logic [29:0] rem;
  logic [30:0] sum;

  assign busy  = (state != S_IDLE);
  assign mul_p = mul_x * mul_y;
  // remainder estimate is below 2p, so the low 32 bits carry it exactly
  assign diff  = prod[31:0] - qp_lo;
  assign sum   = {1'b0, acc} + {1'b0, rem};

  always_comb begin
    unique case (state)
      S_IDLE: begin
        mul_x = {2'b0, req.a};
        mul_y = {2'b0, req.b};
      end
      S_QHI: begin
        mul_x = {2'b0, prod[59:30]};
        mul_y = {1'b0, vmpm_pkg::BARRETT_MU};
      end
      S_QLO: begin
        mul_x = {2'b0, prod[29:0]};
        mul_y = {1'b0, vmpm_pkg::BARRETT_MU};
      end
      S_QMUL: begin
        mul_x = {2'b0, quot};
        mul_y = {2'b0, vmpm_pkg::MODULUS};
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      acc   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            if (req.clear) acc <= '0;
            prod  <= mul_p[59:0];
            state <= S_QHI;
          end else if (req.clear) begin
            acc <= '0;
          end
        end
        S_QHI: begin
          q_hi  <= mul_p;
          state <= S_QLO;
        end
        S_QLO: begin
          q_lo  <= mul_p;
          state <= S_QUOT;
        end
        S_QUOT: begin
          quot  <= 30'((q_hi + (q_lo >> 30)) >> 30);
          state <= S_QMUL;
        end
        S_QMUL: begin
          qp_lo <= mul_p[31:0];
          state <= S_RED;
        end
        S_RED: begin
          rem   <= (diff >= {2'b0, vmpm_pkg::MODULUS}) ?
                   30'(diff - {2'b0, vmpm_pkg::MODULUS}) : diff[29:0];
          state <= S_ADD;
        end
        S_ADD: begin
          acc   <= (sum >= {1'b0, vmpm_pkg::MODULUS}) ?
                   30'(sum - {1'b0, vmpm_pkg::MODULUS}) : sum[29:0];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### sv/vmpm_checker.sv
module vmpm_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [39:0]  m_tdata,
  input logic         m_tlast
);
  // no new request while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("request taken during results");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result dropped");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39:34] == 6'd0) else $error("pad bits set");
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[33:4] < 30'd998244353) else $error("value not reduced");
endmodule

bind vector_matrix_power_mod_prime_unit vmpm_checker u_vmpm_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
